@@ rtl/psd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pairwise squared distance core.
// No dependencies; imported by the register block, datapath and top level.
package psd_pkg;

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Field widths fixed by the interface
    localparam int COORD_W  = 16;
    localparam int POINT_W  = 8;
    localparam int DIMIDX_W = 4;
    localparam int DIST_W   = 36;
    localparam int SQ_W     = 32;  // |a - b| <= 65535, so its square fits 32 bits

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration registers
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int POINTS_W = 9;
    localparam int DIMS_W   = 5;

    localparam logic REG_POINTS = 1'b0;
    localparam logic REG_DIMS   = 1'b1;

    localparam logic [POINTS_W-1:0] POINTS_RESET = 9'd256;
    localparam logic [DIMS_W-1:0]   DIMS_RESET   = 5'd16;

    // Sequencer to datapath control
    typedef struct packed {
        logic clr;     // start of a query: empty the pipe and the sum
        logic rd_vld;  // store read data is valid this cycle
    } t_dp_ctrl;

endpackage

@@ rtl/psd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/psd_regs.sv @@
`timescale 1ns / 1ps
// APB-style configuration registers: points in use and dimensions in use.
// Depends on psd_pkg.
module psd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psd_pkg::PADDR_W-1:0]   paddr,
    input  logic [psd_pkg::PDATA_W-1:0]   pwdata,
    output logic [psd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [psd_pkg::POINTS_W-1:0]  o_points_in_use,
    output logic [psd_pkg::DIMS_W-1:0]    o_dims_in_use
);
    import psd_pkg::*;

    logic                wr_en;
    logic                reg_sel;
    logic [POINTS_W-1:0] r_points;
    logic [DIMS_W-1:0]   r_dims;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];  // word-aligned decode

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= POINTS_RESET;
            r_dims   <= DIMS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_POINTS: r_points <= pwdata[POINTS_W-1:0];
                REG_DIMS:   r_dims   <= pwdata[DIMS_W-1:0];
                default:    r_points <= r_points;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_POINTS: prdata = PDATA_W'(r_points);
            REG_DIMS:   prdata = PDATA_W'(r_dims);
            default:    prdata = '0;
        endcase
    end

    assign o_points_in_use = r_points;
    assign o_dims_in_use   = r_dims;

endmodule

@@ rtl/psd_datapath.sv @@
`timescale 1ns / 1ps
// Difference, square and accumulate pipe fed by the two coordinate stores.
// Depends on psd_pkg.
module psd_datapath #(
    parameter int MAX_DIMS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  psd_pkg::t_dp_ctrl                     i_ctrl,
    input  logic signed [psd_pkg::COORD_W-1:0]    i_coord_a,
    input  logic signed [psd_pkg::COORD_W-1:0]    i_coord_b,
    output logic [psd_pkg::SQ_W+$clog2(MAX_DIMS+1)-1:0] o_acc,
    output logic                                  o_busy
);
    import psd_pkg::*;

    localparam int ACW = SQ_W + $clog2(MAX_DIMS + 1);

    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      abs_diff;
    logic                    r_v_diff;
    logic [COORD_W-1:0]      r_absd;
    logic                    r_v_sq;
    logic [SQ_W-1:0]         r_sq;
    logic [ACW-1:0]          r_acc;

    // 17-bit difference; its magnitude always fits 16 bits
    assign diff     = {i_coord_a[COORD_W-1], i_coord_a} - {i_coord_b[COORD_W-1], i_coord_b};
    assign abs_diff = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_v_diff <= 1'b0;
            r_v_sq   <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_v_diff <= i_ctrl.rd_vld;
            r_v_sq   <= r_v_diff;
            if (r_v_sq) begin
                r_acc <= r_acc + ACW'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_absd <= abs_diff;
        r_sq   <= r_absd * r_absd;
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v_diff | r_v_sq;

endmodule

@@ rtl/pairwise_squared_distance_core.sv @@
`timescale 1ns / 1ps
// Top level of the pairwise squared distance core: item sequencer, coordinate stores,
// result register. Depends on psd_pkg, psd_ram, psd_regs and psd_datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | into core | i_in_valid / o_in_stall    | operation, point_a, point_b,
//          |           |                            | dim_index, coord_value
//  out     | from core | o_out_valid / i_out_stall  | sq_distance, status
//  cfg     | into core | psel, penable, pwrite      | paddr, pwdata, prdata (pready = 1)
//
// A load inside the stores writes both of them in the cycle it is accepted.
// A query is accepted, reads the stores once per dimension, drains the read / difference /
// square / accumulate pipe and then registers the result; out-of-range, same-point and
// zero-dim queries go straight from acceptance to registering the result. The store read
// port reads one coordinate pair per cycle.
// Reset clears the sequencer, the output valid flag and the configuration; the stores are
// not cleared and must be loaded before they are queried.
// A stalled output holds its item while the next item is accepted; a second query waits
// in its final state until the output register frees.

module pairwise_squared_distance_core #(
    parameter int MAX_POINTS = 256,
    parameter int MAX_DIMS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [psd_pkg::POINT_W-1:0]         i_point_a,
    input  logic [psd_pkg::POINT_W-1:0]         i_point_b,
    input  logic [psd_pkg::DIMIDX_W-1:0]        i_dim_index,
    input  logic signed [psd_pkg::COORD_W-1:0]  i_coord_value,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [psd_pkg::DIST_W-1:0]          o_sq_distance,
    output logic                                o_status,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psd_pkg::PADDR_W-1:0]         paddr,
    input  logic [psd_pkg::PDATA_W-1:0]         pwdata,
    output logic [psd_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import psd_pkg::*;

    // Index widths; a store row is a power of two wide so the address is {point, dim}
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW    = PW + DW;
    localparam int DEPTH = 2 ** AW;
    localparam int KW    = $clog2(MAX_DIMS + 1);
    localparam int ACW   = SQ_W + KW;
    localparam int PXW   = (PW > POINT_W) ? PW : POINT_W;
    localparam int DXW   = (DW > DIMIDX_W) ? DW : DIMIDX_W;
    localparam int PCW   = ($clog2(MAX_POINTS + 1) > POINTS_W) ? $clog2(MAX_POINTS + 1)
                                                                : POINTS_W;
    localparam int DCW   = (KW > DIMS_W) ? KW : DIMS_W;
    localparam int SXW   = (ACW > DIST_W + 1) ? ACW : DIST_W + 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_dlim;
    logic [PW-1:0] r_pa, r_pb;
    logic        r_err, r_zero;
    logic        r_rd_vld;
    logic        r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic        r_status;

    logic [POINTS_W-1:0] points_in_use;
    logic [DIMS_W-1:0]   dims_in_use;

    logic              in_acc, load_acc, query_acc;
    logic [PXW-1:0]    pa_ext, pb_ext;
    logic [DXW-1:0]    dim_ext;
    logic [PW-1:0]     pa_idx, pb_idx;
    logic [DW-1:0]     dim_idx;
    logic [PCW-1:0]    pts_ext, plim;
    logic [DCW-1:0]    dims_ext, dlim;
    logic              load_ok, q_err, q_zero;
    logic              issue, last_issue, out_free, finish;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;
    logic [COORD_W-1:0] rdata_a, rdata_b;
    t_dp_ctrl          dp_ctrl;
    logic [ACW-1:0]    acc;
    logic              dp_busy;
    logic [SXW-1:0]    acc_ext;
    logic [DIST_W-1:0] dist_sat;

    psd_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_points_in_use (points_in_use),
        .o_dims_in_use   (dims_in_use)
    );

    // ---------------------------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------------------------
    assign in_acc    = i_in_valid & ~o_in_stall;
    assign load_acc  = in_acc & (i_operation == OP_LOAD);
    assign query_acc = in_acc & (i_operation == OP_QUERY);

    assign pa_ext  = PXW'(i_point_a);
    assign pb_ext  = PXW'(i_point_b);
    assign dim_ext = DXW'(i_dim_index);
    assign pa_idx  = pa_ext[PW-1:0];
    assign pb_idx  = pb_ext[PW-1:0];
    assign dim_idx = dim_ext[DW-1:0];

    // Clamp the configured counts to what the stores hold
    assign pts_ext  = PCW'(points_in_use);
    assign plim     = (pts_ext > PCW'(MAX_POINTS)) ? PCW'(MAX_POINTS) : pts_ext;
    assign dims_ext = DCW'(dims_in_use);
    assign dlim     = (dims_ext > DCW'(MAX_DIMS)) ? DCW'(MAX_DIMS) : dims_ext;

    // Drop loads that fall outside the stores; they are not checked against the counts
    assign load_ok = (PCW'(i_point_a) < PCW'(MAX_POINTS)) &&
                     (DCW'(i_dim_index) < DCW'(MAX_DIMS));

    assign q_err  = (PCW'(i_point_a) >= plim) || (PCW'(i_point_b) >= plim);
    assign q_zero = q_err || (i_point_a == i_point_b) || (dlim == '0);

    // ---------------------------------------------------------------------------------
    // Coordinate stores: two copies written alike, so one pair is read per cycle.
    // Loads are only taken in idle and reads only run after, so a read never meets a
    // write to the same entry in the same cycle.
    // ---------------------------------------------------------------------------------
    assign waddr   = {pa_idx, dim_idx};
    assign raddr_a = {r_pa, r_k[DW-1:0]};
    assign raddr_b = {r_pb, r_k[DW-1:0]};

    psd_ram #(
        .WIDTH (COORD_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (load_acc & load_ok),
        .i_waddr (waddr),
        .i_wdata (i_coord_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    psd_ram #(
        .WIDTH (COORD_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (load_acc & load_ok),
        .i_waddr (waddr),
        .i_wdata (i_coord_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // ---------------------------------------------------------------------------------
    // Difference / square / accumulate pipe
    // ---------------------------------------------------------------------------------
    assign dp_ctrl.clr    = query_acc;
    assign dp_ctrl.rd_vld = r_rd_vld;

    psd_datapath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (dp_ctrl),
        .i_coord_a (rdata_a),
        .i_coord_b (rdata_b),
        .o_acc     (acc),
        .o_busy    (dp_busy)
    );

    // Saturate the sum to the result width
    assign acc_ext  = SXW'(acc);
    assign dist_sat = (acc_ext > SXW'(DIST_MAX)) ? DIST_MAX : acc_ext[DIST_W-1:0];

    // ---------------------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------------------
    assign issue      = (r_state == ST_RUN);
    assign last_issue = issue && (KW'(r_k + 1'b1) == r_dlim);
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign finish     = (r_state == ST_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                n_k = '0;
                if (query_acc) begin
                    n_state = q_zero ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                n_k = KW'(r_k + 1'b1);
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // hold until the last pair has reached the sum
                if (!r_rd_vld && !dp_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_rd_vld <= issue;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query context and result payload
    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_pa   <= pa_idx;
            r_pb   <= pb_idx;
            r_dlim <= dlim[KW-1:0];
            r_err  <= q_err;
            r_zero <= q_zero;
        end
        if (finish) begin
            r_dist   <= r_zero ? '0 : dist_sat;
            r_status <= r_err ? STATUS_RANGE : STATUS_OK;
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_sq_distance = r_dist;
    assign o_status      = r_status;

endmodule
